// ===== src/drt_pkg.sv =====
// shared types and codes for the dirty rectangle tracker
// used by drt_ctrl, drt_dpath and dirty_rect_tracker_top; no dependencies
package drt_pkg;

    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] OUT_ZERO  = 2'd0;
    localparam logic [1:0] OUT_ITEM  = 2'd1;
    localparam logic [1:0] OUT_RD    = 2'd2;
    localparam logic [1:0] OUT_MERGE = 2'd3;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] w;
        logic [31:0] h;
    } t_box;

    typedef struct packed {
        logic       ld_item;
        logic       rd_en;
        logic       acc_load;
        logic       acc_merge;
        logic       merge_rd;
        logic       wr_en;
        logic       wr_merge;
        logic       out_load;
        logic [1:0] out_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       mark_empty;
        logic [2:0] read_index;
        logic       out_free;
    } t_stat;

endpackage

// ===== src/drt_dpath.sv =====
// datapath of the dirty rectangle tracker: beat register, slot memory,
// bounding box merge unit, accumulator and output register; uses drt_pkg
module drt_dpath
    import drt_pkg::*;
#(
    parameter int MAX_SLOTS = 8,
    localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int CW  = $clog2(MAX_SLOTS + 1),
    localparam int RCW = (CW > 4) ? CW : 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [CW-1:0] i_out_cnt,
    input  logic          i_out_col,
    output t_stat         o_stat,
    input  logic [1:0]    i_operation,
    input  logic [31:0]   i_rect_x,
    input  logic [31:0]   i_rect_y,
    input  logic [31:0]   i_rect_width,
    input  logic [31:0]   i_rect_height,
    input  logic [2:0]    i_read_index,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output t_box          o_entry,
    output logic          o_entry_valid,
    output logic [3:0]    o_region_count,
    output logic          o_is_collapsed
);

    function automatic t_box f_merge(t_box a, t_box b);
        logic signed [33:0] ax1, bx1, ay1, by1, x1, y1;
        logic [31:0]        x0, y0;
        t_box               r;
        ax1 = $signed({{2{a.x[31]}}, a.x}) + $signed({2'b00, a.w});
        bx1 = $signed({{2{b.x[31]}}, b.x}) + $signed({2'b00, b.w});
        ay1 = $signed({{2{a.y[31]}}, a.y}) + $signed({2'b00, a.h});
        by1 = $signed({{2{b.y[31]}}, b.y}) + $signed({2'b00, b.h});
        x1  = (ax1 > bx1) ? ax1 : bx1;
        y1  = (ay1 > by1) ? ay1 : by1;
        x0  = ($signed(a.x) < $signed(b.x)) ? a.x : b.x;
        y0  = ($signed(a.y) < $signed(b.y)) ? a.y : b.y;
        r.x = x0;
        r.y = y0;
        r.w = x1[31:0] - x0;
        r.h = y1[31:0] - y0;
        return r;
    endfunction

    t_box          r_mem [MAX_SLOTS];
    t_box          r_item;
    logic [1:0]    r_op;
    logic [2:0]    r_idx;
    t_box          r_rd;
    t_box          r_acc;
    t_box          r_out;
    logic          r_out_ev;
    logic [CW-1:0] r_out_cnt;
    logic          r_out_col;
    logic          r_out_valid;
    t_box          w_merge;
    t_box          w_wr_data;
    logic [RCW-1:0] w_cnt_ext;

    assign w_merge   = f_merge(r_acc, i_cmd.merge_rd ? r_rd : r_item);
    assign w_wr_data = i_cmd.wr_merge ? w_merge : r_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_item <= '{x: i_rect_x, y: i_rect_y, w: i_rect_width, h: i_rect_height};
            r_op   <= i_operation;
            r_idx  <= i_read_index;
        end
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
        if (i_cmd.acc_load) begin
            r_acc <= r_rd;
        end else if (i_cmd.acc_merge) begin
            r_acc <= w_merge;
        end
        if (i_cmd.out_load) begin
            r_out_cnt <= i_out_cnt;
            r_out_col <= i_out_col;
            case (i_cmd.out_sel)
                OUT_ITEM: begin
                    r_out    <= r_item;
                    r_out_ev <= 1'b1;
                end
                OUT_RD: begin
                    r_out    <= r_rd;
                    r_out_ev <= 1'b1;
                end
                OUT_MERGE: begin
                    r_out    <= w_merge;
                    r_out_ev <= 1'b1;
                end
                default: begin
                    r_out    <= '0;
                    r_out_ev <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.mark_empty = (r_item.w == '0) || (r_item.h == '0);
    assign o_stat.read_index = r_idx;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign w_cnt_ext      = RCW'(r_out_cnt);
    assign o_out_valid    = r_out_valid;
    assign o_entry        = r_out;
    assign o_entry_valid  = r_out_ev;
    assign o_region_count = w_cnt_ext[3:0];
    assign o_is_collapsed = r_out_col;

endmodule

// ===== src/drt_ctrl.sv =====
// controller of the dirty rectangle tracker: sequences decode, slot reads,
// the collapse walk and result loads; keeps the count and collapsed flag; uses drt_pkg
module drt_ctrl
    import drt_pkg::*;
#(
    parameter int MAX_SLOTS = 8,
    localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int CW   = $clog2(MAX_SLOTS + 1),
    localparam int CMPW = (CW > 3) ? CW : 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_stat         i_stat,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_rd_addr,
    output logic [AW-1:0] o_wr_addr,
    output logic [CW-1:0] o_out_cnt,
    output logic          o_out_col
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;
    localparam logic [2:0] S_RDOUT  = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_col, n_col;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic            r_walk, n_walk;
    logic [CMPW-1:0] w_idx_ext;
    logic            w_idx_ok;

    assign w_idx_ext = CMPW'(i_stat.read_index);
    assign w_idx_ok  = w_idx_ext < CMPW'(r_cnt);
    assign o_ready   = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_col     = r_col;
        n_ptr     = r_ptr;
        n_walk    = r_walk;
        o_cmd     = '0;
        o_cmd.ld_item = 1'b0;
        o_rd_addr = '0;
        o_wr_addr = r_cnt[AW-1:0];
        o_out_cnt = r_cnt;
        o_out_col = r_col;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == OP_MARK && !i_stat.mark_empty && r_col) begin
                    o_cmd.rd_en = 1'b1;
                    n_walk      = 1'b0;
                    n_state     = S_LOAD;
                end else if (i_stat.op == OP_MARK && !i_stat.mark_empty &&
                             r_cnt >= CW'(MAX_SLOTS)) begin
                    o_cmd.rd_en = 1'b1;
                    n_walk      = 1'b1;
                    n_ptr       = CW'(1);
                    n_state     = S_LOAD;
                end else if (i_stat.op == OP_READ && w_idx_ok) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = w_idx_ext[AW-1:0];
                    n_state     = S_RDOUT;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                    if (i_stat.op == OP_MARK && !i_stat.mark_empty) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.out_sel = OUT_ITEM;
                        n_cnt         = r_cnt + CW'(1);
                    end else begin
                        o_cmd.out_sel = OUT_ZERO;
                        if (i_stat.op == OP_CLEAR) begin
                            n_cnt = '0;
                            n_col = 1'b0;
                        end
                    end
                    o_out_cnt = n_cnt;
                    o_out_col = n_col;
                end
            end
            S_LOAD: begin
                o_cmd.acc_load = 1'b1;
                if (r_walk) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = r_ptr[AW-1:0];
                    n_ptr       = r_ptr + CW'(1);
                    n_state     = S_WALK;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_WALK: begin
                o_cmd.acc_merge = 1'b1;
                o_cmd.merge_rd  = 1'b1;
                if (r_ptr < CW'(MAX_SLOTS)) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = r_ptr[AW-1:0];
                    n_ptr       = r_ptr + CW'(1);
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.acc_merge = 1'b1;
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_merge  = 1'b1;
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel   = OUT_MERGE;
                    o_wr_addr       = '0;
                    n_cnt           = CW'(1);
                    n_col           = 1'b1;
                    o_out_cnt       = n_cnt;
                    o_out_col       = n_col;
                    n_state         = S_IDLE;
                end
            end
            S_RDOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_RD;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_col   <= 1'b0;
            r_ptr   <= '0;
            r_walk  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_ptr   <= n_ptr;
            r_walk  <= n_walk;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_SLOTS))
        else $error("slot count above capacity");

    a_col_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col |-> (r_cnt == CW'(1)))
        else $error("collapsed list must hold one slot");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded over a pending beat");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_item |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");
`endif

endmodule

// ===== src/dirty_rect_tracker_top.sv =====
// Dirty rectangle tracker: keeps up to MAX_SLOTS damaged rectangles in a slot
// memory with one read port and one write port. A mark with zero width or height
// gives an invalid result. Marks append until the list is full; the next mark
// merges every slot and itself into one bounding box in slot 0 and the list stays
// collapsed, each later mark widening slot 0, until a clear. Each beat gives one
// result. Appends, clears, ignored marks and invalid reads finish in decode; a
// valid read finishes in read-out; a collapsed mark merges into slot 0 in the
// final state, and the collapsing mark first walks the other slots, one slot per
// cycle through the single read port. A new beat is taken while the last result
// still waits in the output register. Depends on drt_pkg, drt_ctrl and drt_dpath.
module dirty_rect_tracker_top
    import drt_pkg::*;
#(
    parameter int MAX_SLOTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_rect_x,
    input  logic signed [31:0] i_rect_y,
    input  logic [31:0]        i_rect_width,
    input  logic [31:0]        i_rect_height,
    input  logic [2:0]         i_read_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_entry_x,
    output logic signed [31:0] o_entry_y,
    output logic [31:0]        o_entry_width,
    output logic [31:0]        o_entry_height,
    output logic               o_entry_valid,
    output logic [3:0]         o_region_count,
    output logic               o_is_collapsed
);

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic [CW-1:0] w_out_cnt;
    logic          w_out_col;
    t_box          w_entry;

    drt_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_rd_addr (w_rd_addr),
        .o_wr_addr (w_wr_addr),
        .o_out_cnt (w_out_cnt),
        .o_out_col (w_out_col)
    );

    drt_dpath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_rd_addr      (w_rd_addr),
        .i_wr_addr      (w_wr_addr),
        .i_out_cnt      (w_out_cnt),
        .i_out_col      (w_out_col),
        .o_stat         (w_stat),
        .i_operation    (i_operation),
        .i_rect_x       (i_rect_x),
        .i_rect_y       (i_rect_y),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_read_index   (i_read_index),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_entry        (w_entry),
        .o_entry_valid  (o_entry_valid),
        .o_region_count (o_region_count),
        .o_is_collapsed (o_is_collapsed)
    );

    assign o_entry_x      = w_entry.x;
    assign o_entry_y      = w_entry.y;
    assign o_entry_width  = w_entry.w;
    assign o_entry_height = w_entry.h;

endmodule
